// File: rtl/sorted_key_table_unit_defines.svh
// Assertion macros shared by the sorted key table RTL.
`ifndef SORTED_KEY_TABLE_UNIT_DEFINES_SVH
`define SORTED_KEY_TABLE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SKT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted key table: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SKT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted key table: next-cycle check failed");

`endif

// File: rtl/skt_pkg.sv
// Types and codes shared by the sorted key table modules.
`timescale 1ns / 1ps
package skt_pkg;

  localparam int KEY_W = 32;
  localparam int IDX_W = 4;
  localparam int CNT_W = 5;
  localparam int ACT_W = 2;
  localparam int ST_W  = 2;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [ACT_W-1:0] action_t;
  typedef logic [ST_W-1:0]  status_t;

  localparam action_t ACT_INSERT = 2'd0;
  localparam action_t ACT_LOOKUP = 2'd1;
  localparam action_t ACT_REMOVE = 2'd2;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_FULL      = 2'd1;
  localparam status_t ST_BAD_INDEX = 2'd2;

  typedef struct packed {
    logic ins;
    logic rem;
    key_t key;
  } cell_ctrl_t;

endpackage

// File: rtl/skt_cell.sv
// One cell of the sorted key chain: holds one key and shifts with its neighbors.
`timescale 1ns / 1ps
module skt_cell import skt_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       left_lt,
  input  key_t       left_val,
  input  key_t       right_val,
  input  logic       occupied,
  input  logic       shift_down,
  output key_t       val,
  output logic       lt
);

  key_t val_r;
  key_t val_nxt;

  assign lt  = occupied && (val_r < ctrl.key);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.ins) begin
      if (!lt) begin
        val_nxt = left_lt ? ctrl.key : left_val;
      end
    end else if (ctrl.rem && shift_down) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// File: rtl/sorted_key_table_unit.sv
// Top level of the sorted key table: a chain of key cells with count and result logic.
`timescale 1ns / 1ps
// The table keeps up to CAPACITY unsigned keys in ascending order in a row of cells that all
// compare against the incoming key and shift in the same clock cycle. Busy stays low, a new
// transaction may start in every cycle, and its result appears on the out_ ports with out_valid
// high for exactly one cycle, the cycle after start. The result must be captured in that cycle
// because the receiver cannot stall the block. Each cell makes one key comparison and passes its
// less-than flag to the next cell. Entries not yet written hold no defined value and are never
// returned.
`include "sorted_key_table_unit_defines.svh"
module sorted_key_table_unit import skt_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [ACT_W-1:0] in_action,
  input  logic [KEY_W-1:0] in_key,
  input  logic [IDX_W-1:0] in_index,
  output logic             out_valid,
  output logic [KEY_W-1:0] out_value,
  output logic [CNT_W-1:0] out_count,
  output logic [ST_W-1:0]  out_status
);

  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CW > IDX_W) ? CW : IDX_W;
  localparam int LOOK_N = 2 ** IDX_W;

  logic [CW-1:0]    cnt_r;
  logic [CW-1:0]    cnt_nxt;
  logic             out_valid_r;
  key_t             out_value_r;
  logic [CNT_W-1:0] out_count_r;
  status_t          out_status_r;

  logic             accept;
  logic             full;
  logic             index_ok;
  logic [CMP_W-1:0] idx_ext;
  cell_ctrl_t       ctrl;
  key_t             value_nxt;
  status_t          status_nxt;

  key_t             cell_val [CAPACITY];
  logic             cell_lt  [CAPACITY];
  key_t             look_val [LOOK_N];

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign full     = (cnt_r == CW'(CAPACITY));
  assign idx_ext  = CMP_W'(in_index);
  assign index_ok = (idx_ext < CMP_W'(cnt_r));

  always_comb begin
    ctrl.ins = accept && (in_action == ACT_INSERT) && !full;
    ctrl.rem = accept && (in_action == ACT_REMOVE) && index_ok;
    ctrl.key = in_key;
  end

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic left_lt;
      key_t left_val;
      key_t right_val;
      logic occupied;
      logic shift_down;

      if (i == 0) begin : g_first
        assign left_lt  = 1'b1;
        assign left_val = in_key;
      end else begin : g_inner
        assign left_lt  = cell_lt[i-1];
        assign left_val = cell_val[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
        assign right_val = cell_val[i];
      end else begin : g_body
        assign right_val = cell_val[i+1];
      end

      assign occupied   = (CW'(i) < cnt_r);
      assign shift_down = (CMP_W'(i) >= idx_ext);

      skt_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .left_lt    (left_lt),
        .left_val   (left_val),
        .right_val  (right_val),
        .occupied   (occupied),
        .shift_down (shift_down),
        .val        (cell_val[i]),
        .lt         (cell_lt[i])
      );
    end

    for (i = 0; i < LOOK_N; i++) begin : g_look
      if (i < CAPACITY) begin : g_real
        assign look_val[i] = cell_val[i];
      end else begin : g_none
        assign look_val[i] = '0;
      end
    end
  endgenerate

  always_comb begin
    cnt_nxt    = cnt_r;
    value_nxt  = '0;
    status_nxt = ST_OK;
    if (accept) begin
      case (in_action)
        ACT_INSERT: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            cnt_nxt = cnt_r + CW'(1);
          end
        end
        ACT_LOOKUP: begin
          if (index_ok) begin
            value_nxt = look_val[in_index];
          end else begin
            status_nxt = ST_BAD_INDEX;
          end
        end
        ACT_REMOVE: begin
          if (index_ok) begin
            cnt_nxt = cnt_r - CW'(1);
          end else begin
            status_nxt = ST_BAD_INDEX;
          end
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= value_nxt;
    out_count_r  <= CNT_W'(cnt_nxt);
    out_status_r <= status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_count  = out_count_r;
  assign out_status = out_status_r;

  `SKT_ASSERT_SAME(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CW'(CAPACITY))
  `SKT_ASSERT_NEXT(a_strobe_follows, clk, rst_n, accept, out_valid_r)
  `SKT_ASSERT_NEXT(a_insert_grows, clk, rst_n, ctrl.ins, cnt_r == $past(cnt_r) + CW'(1))
  `SKT_ASSERT_SAME(a_err_zero, clk, rst_n, out_valid_r && (out_status_r != ST_OK), out_value_r == '0)
  `SKT_ASSERT_SAME(a_head_sorted, clk, rst_n, cnt_r >= CW'(2), cell_val[0] <= cell_val[1])

endmodule
